/* design/pofl_pkg.sv */
package pofl_pkg;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ALLOC  = 3'd1;
  localparam logic [2:0] CMD_PUSH   = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  order;
    logic [47:0] paddr;
    logic [13:0] node;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] node_out;
    logic [47:0] addr_out;
  } result_t;

endpackage

/* design/per_order_free_list_manager_top.sv */
// Clear, allocate, push, unused codes, and pop or remove on an empty or absent list:
//   result strobed in the cycle after the transfer; busy stays low, one command per cycle.
// Pop of a non-empty list: one node read in S_POP, then the result is registered; busy 1 cycle.
// Remove on a non-empty list: S_WALK visits k nodes, then the result is registered; busy throughout,
//   k = nodes visited (1 to POOL_DEPTH), paced by the registered read of the node memories.
// Reset: lists empty, counter zero, node memories left as is; results are never held off.
module per_order_free_list_manager_top
  import pofl_pkg::*;
#(
  parameter int POOL_DEPTH  = 16384,
  parameter int ORDER_COUNT = 11,
  parameter int ADDR_BITS   = 48
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int NW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int OW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int AW = ADDR_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]    state, state_next;
  logic          done_next;
  logic [CW-1:0] nodes_used, nodes_used_next;
  logic          head_valid [ORDER_COUNT];
  logic          head_valid_next [ORDER_COUNT];
  logic [NW-1:0] head_idx [ORDER_COUNT];
  logic [NW-1:0] head_idx_next [ORDER_COUNT];

  logic [OW-1:0] ord_q, ord_q_next;
  logic [AW-1:0] addr_q, addr_q_next;
  logic [NW-1:0] cur_q, cur_q_next;
  logic [NW-1:0] prev_q, prev_q_next;
  logic          prev_valid_q, prev_valid_q_next;
  logic [CW-1:0] steps_q, steps_q_next;
  logic [CW-1:0] visited;

  logic [1:0]    res_status, res_status_next;
  logic [NW-1:0] res_node, res_node_next;
  logic [AW-1:0] res_addr, res_addr_next;

  logic          addr_we;
  logic [NW-1:0] addr_waddr;
  logic [AW-1:0] addr_wdata;
  logic [AW-1:0] addr_rd;
  logic          next_we;
  logic [NW-1:0] next_waddr;
  logic [NW:0]   next_wdata;
  logic [NW:0]   next_rd;
  logic          rd_en;
  logic [NW-1:0] rd_addr;

  logic [31:0]   node_in_ext;
  logic [NW-1:0] node_in_idx;
  logic          node_in_ok;
  logic [7:0]    ord_in_ext;
  logic [OW-1:0] ord_in_idx;
  logic          ord_in_ok;
  logic          head_in_valid;
  logic [63:0]   addr_in_ext;
  logic [AW-1:0] addr_in;
  logic          pool_full;
  logic          accept;
  logic [31:0]   res_node_ext;
  logic [63:0]   res_addr_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign node_in_ext   = 32'(item.node);
  assign node_in_idx   = node_in_ext[NW-1:0];
  assign node_in_ok    = (node_in_ext < 32'(POOL_DEPTH));
  assign ord_in_ext    = 8'(item.order);
  assign ord_in_idx    = ord_in_ext[OW-1:0];
  assign ord_in_ok     = (ord_in_ext < 8'(ORDER_COUNT));
  assign head_in_valid = ord_in_ok && head_valid[ord_in_idx];
  assign addr_in_ext   = 64'(item.paddr);
  assign addr_in       = addr_in_ext[AW-1:0];
  assign pool_full     = (nodes_used == CW'(POOL_DEPTH));
  assign visited       = steps_q + 1'b1;

  always_comb begin
    state_next        = state;
    done_next         = 1'b0;
    nodes_used_next   = nodes_used;
    head_valid_next   = head_valid;
    head_idx_next     = head_idx;
    ord_q_next        = ord_q;
    addr_q_next       = addr_q;
    cur_q_next        = cur_q;
    prev_q_next       = prev_q;
    prev_valid_q_next = prev_valid_q;
    steps_q_next      = steps_q;
    res_status_next   = res_status;
    res_node_next     = res_node;
    res_addr_next     = res_addr;
    addr_we           = 1'b0;
    addr_waddr        = nodes_used[NW-1:0];
    addr_wdata        = addr_in;
    next_we           = 1'b0;
    next_waddr        = nodes_used[NW-1:0];
    next_wdata        = '0;
    rd_en             = 1'b0;
    rd_addr           = next_rd[NW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_node_next   = '0;
          res_addr_next   = '0;
          done_next       = 1'b1;
          case (item.command)
            CMD_CLEAR: begin
              head_valid_next = '{default: 1'b0};
              nodes_used_next = '0;
            end
            CMD_ALLOC: begin
              if (pool_full) begin
                res_status_next = ST_EXHAUSTED;
              end else begin
                addr_we         = 1'b1;
                next_we         = 1'b1;
                nodes_used_next = nodes_used + 1'b1;
                res_node_next   = nodes_used[NW-1:0];
                res_addr_next   = addr_in;
              end
            end
            CMD_PUSH: begin
              if (ord_in_ok && node_in_ok) begin
                next_we                     = 1'b1;
                next_waddr                  = node_in_idx;
                next_wdata                  = {head_valid[ord_in_idx], head_idx[ord_in_idx]};
                head_valid_next[ord_in_idx] = 1'b1;
                head_idx_next[ord_in_idx]   = node_in_idx;
              end
            end
            CMD_POP: begin
              if (!head_in_valid) begin
                res_status_next = ST_EMPTY;
              end else begin
                done_next  = 1'b0;
                rd_en      = 1'b1;
                rd_addr    = head_idx[ord_in_idx];
                cur_q_next = head_idx[ord_in_idx];
                ord_q_next = ord_in_idx;
                state_next = S_POP;
              end
            end
            CMD_REMOVE: begin
              if (!head_in_valid) begin
                res_status_next = ST_NOT_FOUND;
              end else begin
                done_next         = 1'b0;
                rd_en             = 1'b1;
                rd_addr           = head_idx[ord_in_idx];
                cur_q_next        = head_idx[ord_in_idx];
                ord_q_next        = ord_in_idx;
                addr_q_next       = addr_in;
                prev_valid_q_next = 1'b0;
                steps_q_next      = '0;
                state_next        = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        head_valid_next[ord_q] = next_rd[NW];
        head_idx_next[ord_q]   = next_rd[NW-1:0];
        res_status_next        = ST_OK;
        res_node_next          = cur_q;
        res_addr_next          = addr_rd;
        done_next              = 1'b1;
        state_next             = S_IDLE;
      end
      S_WALK: begin
        if (addr_rd == addr_q) begin
          if (prev_valid_q) begin
            next_we    = 1'b1;
            next_waddr = prev_q;
            next_wdata = next_rd;
          end else begin
            head_valid_next[ord_q] = next_rd[NW];
            head_idx_next[ord_q]   = next_rd[NW-1:0];
          end
          res_status_next = ST_OK;
          res_node_next   = cur_q;
          res_addr_next   = addr_rd;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else if (!next_rd[NW] || visited == CW'(POOL_DEPTH)) begin
          res_status_next = ST_NOT_FOUND;
          res_node_next   = '0;
          res_addr_next   = '0;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          prev_q_next       = cur_q;
          prev_valid_q_next = 1'b1;
          cur_q_next        = next_rd[NW-1:0];
          steps_q_next      = visited;
          rd_en             = 1'b1;
          rd_addr           = next_rd[NW-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      nodes_used <= '0;
      head_valid <= '{default: 1'b0};
    end else begin
      state      <= state_next;
      done       <= done_next;
      nodes_used <= nodes_used_next;
      head_valid <= head_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    head_idx     <= head_idx_next;
    ord_q        <= ord_q_next;
    addr_q       <= addr_q_next;
    cur_q        <= cur_q_next;
    prev_q       <= prev_q_next;
    prev_valid_q <= prev_valid_q_next;
    steps_q      <= steps_q_next;
    res_status   <= res_status_next;
    res_node     <= res_node_next;
    res_addr     <= res_addr_next;
  end

  pofl_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (addr_waddr),
    .wdata (addr_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (addr_rd)
  );

  pofl_ram #(
    .WIDTH (NW + 1),
    .DEPTH (POOL_DEPTH)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  assign res_node_ext    = 32'(res_node);
  assign res_addr_ext    = 64'(res_addr);
  assign result.status   = res_status;
  assign result.node_out = res_node_ext[13:0];
  assign result.addr_out = res_addr_ext[47:0];

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= CW'(POOL_DEPTH))
    else $error("node counter beyond pool depth");

  a_exhausted_only_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EXHAUSTED) |-> $past(nodes_used) == CW'(POOL_DEPTH))
    else $error("pool exhausted reported while pool had room");

  a_pop_one_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (done && state == S_IDLE))
    else $error("pop did not finish after one read");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> steps_q < CW'(POOL_DEPTH))
    else $error("remove walk exceeded pool depth");

endmodule

/* design/pofl_ram.sv */
module pofl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
